/* src/vtrs_pkg.sv */
`default_nettype none

package vtrs_pkg;

  // Result actions
  localparam logic [2:0] ACT_PROBE      = 3'd0;
  localparam logic [2:0] ACT_COPY_BACK  = 3'd1;
  localparam logic [2:0] ACT_COPY_FRONT = 3'd2;
  localparam logic [2:0] ACT_SWAP       = 3'd3;
  localparam logic [2:0] ACT_DONE       = 3'd4;

  // Input opcodes
  localparam logic OP_FRAME  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SCAN_START = 2'd0;
  localparam logic [1:0] REG_SCAN_END   = 2'd1;
  localparam logic [1:0] REG_FRAME_H    = 2'd2;

  // Tear row value for "no tear"
  localparam logic [12:0] TEAR_NONE = 13'h1FFF;

  // Most results one input item can cause
  localparam int MAX_RESULTS = 3;

  typedef struct packed {
    logic [2:0]  action;
    logic [12:0] row_from;
    logic [12:0] row_to;
    logic [12:0] tear_row;
  } vtrs_result_t;

  // Results of one input item, slot 0 goes out first
  typedef struct packed {
    logic [1:0]                         count;
    vtrs_result_t [MAX_RESULTS-1:0]     res;
  } vtrs_bundle_t;

  function automatic vtrs_result_t mk_result(input logic [2:0] act,
                                             input logic [12:0] from,
                                             input logic [12:0] to,
                                             input logic [12:0] tear);
    vtrs_result_t r;
    r.action   = act;
    r.row_from = from;
    r.row_to   = to;
    r.tear_row = tear;
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/vtrs_front.sv */
`default_nettype none

module vtrs_front
  import vtrs_pkg::*;
#(
  parameter int MAX_ROWS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration writes
  input  wire logic         cfg_valid,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [12:0]  cfg_data,
  // input items
  input  wire logic         in_valid,
  input  wire logic         in_ready,
  input  wire logic         opcode,
  input  wire logic         row_changed,
  // bundle toward the queue
  output logic              push,
  output vtrs_bundle_t      bundle
);

  localparam int CapInt = (MAX_ROWS > 8191) ? 8191 : MAX_ROWS;
  localparam logic [12:0] HeightCap = 13'(CapInt);

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SEARCH} phase_t;

  logic [11:0] scan_start_row;
  logic [11:0] scan_end_row;
  logic [12:0] frame_height;

  phase_t      phase, phase_next;
  logic        pending_copy, pending_copy_next;
  logic        front_done, front_done_next;
  logic [12:0] latest_tear, latest_tear_next;
  logic [12:0] first_new_row, first_new_row_next;
  logic [12:0] previous_row, previous_row_next;
  logic [12:0] current_row, current_row_next;

  logic        accept;
  logic [12:0] height;
  logic [11:0] end_row;
  logic [1:0]  n;
  logic        do_finish;
  logic [12:0] fin_tear;
  logic [12:0] tear_adj;
  logic [13:0] diff;
  logic [12:0] skipped;
  logic [11:0] half;
  logic signed [13:0] next_row;
  logic [12:0] fn_eff;
  logic [12:0] from_tear;

  assign accept  = in_valid && in_ready;
  assign height  = (frame_height > HeightCap) ? HeightCap : frame_height;
  assign end_row = (scan_end_row < scan_start_row) ? scan_start_row : scan_end_row;

  // Search step arithmetic
  always_comb begin
    diff     = {1'b0, current_row} - {1'b0, previous_row};
    skipped  = diff[13] ? 13'(-diff) : diff[12:0];
    half     = (skipped[12:1] == 12'd0) ? 12'd1 : skipped[12:1];
    next_row = row_changed ? $signed({1'b0, current_row}) - $signed({2'b0, half})
                           : $signed({1'b0, current_row}) + $signed({2'b0, half});
    fn_eff   = row_changed ? current_row : first_new_row;
  end

  // Item classification and state update
  always_comb begin
    phase_next         = phase;
    pending_copy_next  = pending_copy;
    front_done_next    = front_done;
    latest_tear_next   = latest_tear;
    first_new_row_next = first_new_row;
    previous_row_next  = previous_row;
    current_row_next   = current_row;
    bundle             = '0;
    n                  = 2'd0;
    do_finish          = 1'b0;
    fin_tear           = TEAR_NONE;
    tear_adj           = TEAR_NONE;
    from_tear          = latest_tear[12] ? 13'd0 : latest_tear;

    if (opcode == OP_FRAME) begin
      front_done_next = 1'b0;
      if (pending_copy) begin
        bundle.res[n] = mk_result(ACT_COPY_BACK, 13'd0, from_tear, 13'd0);
        n = n + 2'd1;
        bundle.res[n] = mk_result(ACT_SWAP, 13'd0, 13'd0, 13'd0);
        n = n + 2'd1;
        pending_copy_next = 1'b0;
        front_done_next   = 1'b1;
      end
      current_row_next = {1'b0, scan_start_row};
      phase_next       = PH_FIRST;
      bundle.res[n] = mk_result(ACT_PROBE, {1'b0, scan_start_row}, 13'd0, 13'd0);
      n = n + 2'd1;
    end else if (phase == PH_FIRST) begin
      if (row_changed) begin
        do_finish = 1'b1;
      end else begin
        first_new_row_next = {1'b0, end_row} + 13'd1;
        previous_row_next  = {1'b0, scan_start_row};
        current_row_next   = {1'b0, scan_start_row}
                           + {2'b0, 11'((end_row - scan_start_row) >> 1)};
        phase_next         = PH_SEARCH;
        bundle.res[n] = mk_result(ACT_PROBE, current_row_next, 13'd0, 13'd0);
        n = n + 2'd1;
      end
    end else if (phase == PH_SEARCH) begin
      first_new_row_next = fn_eff;
      previous_row_next  = current_row;
      if ((next_row == $signed({1'b0, fn_eff})) ||
          (next_row < $signed({2'b0, scan_start_row})) ||
          (next_row > $signed({1'b0, fn_eff}))) begin
        do_finish = 1'b1;
        fin_tear  = (fn_eff > {1'b0, end_row}) ? TEAR_NONE : fn_eff;
      end else begin
        current_row_next = next_row[12:0];
        bundle.res[n] = mk_result(ACT_PROBE, next_row[12:0], 13'd0, 13'd0);
        n = n + 2'd1;
      end
    end

    // End of search: copy command when one is needed, then done report
    if (do_finish) begin
      tear_adj = (!fin_tear[12] && (fin_tear >= height)) ? TEAR_NONE : fin_tear;
      latest_tear_next = tear_adj;
      phase_next       = PH_IDLE;
      if (!tear_adj[12]) begin
        bundle.res[n] = mk_result(ACT_COPY_BACK, tear_adj, height, 13'd0);
        n = n + 2'd1;
        pending_copy_next = 1'b1;
      end else if (!front_done) begin
        bundle.res[n] = mk_result(ACT_COPY_FRONT, 13'd0, height, 13'd0);
        n = n + 2'd1;
      end
      bundle.res[n] = mk_result(ACT_DONE, 13'd0, 13'd0, tear_adj);
      n = n + 2'd1;
    end

    bundle.count = n;
  end

  assign push = accept && (n != 2'd0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_start_row <= 12'd0;
      scan_end_row   <= 12'd4095;
      frame_height   <= 13'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCAN_START: scan_start_row <= cfg_data[11:0];
        REG_SCAN_END:   scan_end_row   <= cfg_data[11:0];
        REG_FRAME_H:    frame_height   <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Search state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pending_copy  <= 1'b0;
      front_done    <= 1'b0;
      latest_tear   <= TEAR_NONE;
      first_new_row <= 13'd0;
      previous_row  <= 13'd0;
      current_row   <= 13'd0;
    end else if (accept) begin
      phase         <= phase_next;
      pending_copy  <= pending_copy_next;
      front_done    <= front_done_next;
      latest_tear   <= latest_tear_next;
      first_new_row <= first_new_row_next;
      previous_row  <= previous_row_next;
      current_row   <= current_row_next;
    end
  end

  // A frame start always leaves the block waiting for the start-row answer
  a_frame_starts_search: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_FRAME)) |=> (phase == PH_FIRST))
    else $error("frame start did not open a search");

endmodule

`default_nettype wire

/* src/vtrs_queue.sv */
`default_nettype none

module vtrs_queue
  import vtrs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire vtrs_bundle_t  push_data,
  output logic               not_full,
  input  wire logic          pop,
  output logic               not_empty,
  output vtrs_bundle_t       head
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  vtrs_bundle_t        mem [Depth];
  logic [PtrW-1:0]     wptr;
  logic [PtrW-1:0]     rptr;
  logic [PtrW:0]       count;

  assign not_full  = (count != (PtrW+1)'(Depth));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> not_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

/* src/vtrs_back.sv */
`default_nettype none

module vtrs_back
  import vtrs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_not_empty,
  input  wire vtrs_bundle_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vtrs_result_t       out_result,
  output logic               out_last
);

  vtrs_bundle_t hold;
  logic         hold_valid;
  logic [1:0]   idx;
  logic         xfer;

  assign out_valid  = hold_valid;
  assign out_result = hold.res[idx];
  assign out_last   = (idx == (hold.count - 2'd1));
  assign xfer       = hold_valid && out_ready;
  assign q_pop      = q_not_empty && (!hold_valid || (xfer && out_last));

  // Bundle holding register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hold <= q_head;
    end
  end

  // Result sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (q_pop) begin
      hold_valid <= 1'b1;
      idx        <= 2'd0;
    end else if (xfer) begin
      if (out_last) begin
        hold_valid <= 1'b0;
        idx        <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (hold.count != 2'd0))
    else $error("empty bundle held for output");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (idx < hold.count))
    else $error("result index past bundle count");

endmodule

`default_nettype wire

/* src/video_tear_row_search.sv */
`default_nettype none

// Tear row search controller.
// Slave stream s_*: one input item per transfer. s_tuser[0] is the opcode
// (0 frame start, 1 answer to the last probe), s_tdata[0] is row_changed.
// Master stream m_*: result items. m_tuser is the action, m_tlast marks the
// final result caused by one input item.
// Configuration channel cfg_*: index 0 scan start row, 1 scan end row,
// 2 frame height; writes complete in the cycle they are offered.
// An input item is classified and its results (up to three) are formed in
// the transfer cycle, then wait in a four-entry queue. The first result of an
// item reaches m_* from the queue through the output holding register.
// Throughput: one input item per cycle while each item causes one result and
// m_tready is high; the output side sends one result per cycle while m_tready
// is high. s_tready drops only when the queue is full or reset is held.
// A stalled m_tready holds the current result and fills the queue.
// Reset clears the search state and loads the register defaults; s_tready
// is high in the first cycle after reset.
module video_tear_row_search
  import vtrs_pkg::*;
#(
  parameter int MAX_ROWS = 4096
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [12:0]  cfg_data,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [0] row_changed, [7:1] zero
  input  wire logic [0:0]   s_tuser,   // [0] opcode
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,   // [12:0] row_from, [25:13] row_to,
                                       // [38:26] tear_row, [39] zero
  output logic [2:0]        m_tuser,   // [2:0] action
  output logic              m_tlast    // last_result
);

  logic         push;
  vtrs_bundle_t push_bundle;
  logic         q_not_full;
  logic         q_not_empty;
  logic         q_pop;
  vtrs_bundle_t q_head;
  vtrs_result_t out_result;

  // no transfers are taken while reset is held
  assign cfg_ready = !rst;
  assign s_tready  = q_not_full && !rst;

  vtrs_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser[0]),
    .row_changed(s_tdata[0]),
    .push       (push),
    .bundle     (push_bundle)
  );

  vtrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_bundle),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  vtrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result),
    .out_last   (m_tlast)
  );

  assign m_tuser = out_result.action;
  assign m_tdata = {1'b0, out_result.tear_row, out_result.row_to, out_result.row_from};

endmodule

`default_nettype wire
